### hw/rtl/contactor_closure_checker_top_assert.svh
// assertion macros for the contactor closure checker
// included by contactor_closure_checker_top.sv, no other dependencies
`ifndef CONTACTOR_CLOSURE_CHECKER_TOP_ASSERT_SVH
`define CONTACTOR_CLOSURE_CHECKER_TOP_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define CCC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("contactor closure checker: same-cycle check failed");

// next-cycle implication, checked while out of reset
`define CCC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("contactor closure checker: next-cycle check failed");

`endif

### hw/rtl/ccc_pkg.sv
// types and constants for the contactor closure checker
// no dependencies; used by contactor_closure_checker_top
`timescale 1ns / 1ps

package ccc_pkg;

    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 12;
    localparam int SAMPLE_W    = 12;
    localparam int MULT_W      = 8;
    localparam int ATTEMPT_W   = 8;
    localparam int OUTCOME_W   = 3;

    localparam logic [SAMPLE_W-1:0]  SPREAD_LIMIT_RST = 12'd10;
    localparam logic [ATTEMPT_W-1:0] MAX_ATTEMPTS_RST = 8'd50;

    // current threshold: 264 * v against 5 * full scale * multiplier
    localparam int CURRENT_SCALE = 264;

    typedef enum logic {
        REQ_START  = 1'b0,
        REQ_SAMPLE = 1'b1
    } req_type_t;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_SET        = 3'd0,
        OUT_CONV_ERROR = 3'd1,
        OUT_UNSETTLED  = 3'd2,
        OUT_CURR_HIGH  = 3'd3,
        OUT_PIN_OPEN   = 3'd4
    } outcome_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SPREAD_LIMIT = 1'b0,
        REG_MAX_ATTEMPTS = 1'b1
    } cfg_reg_t;

endpackage

### hw/rtl/contactor_closure_checker_top.sv
// contactor closure checker: arms on a start transaction, judges ADC attempts
// depends on ccc_pkg and contactor_closure_checker_top_assert.svh
//
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+-----------------------------------
//  s_        | in        | s_tvalid / s_tready    | s_tuser req_type, s_tdata fields
//  m_        | out       | m_tvalid / m_tready    | m_tdata result fields
//  cfg_      | in        | cfg_valid / cfg_ready  | cfg_index, cfg_wdata
//
// one transaction per cycle while the result is not stalled; a result passes through
// the input register, then the result register; all check state updates in one pass
// reset clears control state and restores spread limit 10, attempt limit 50
// a stalled result holds; the input register still refills once the result leaves
// configuration writes are always ready and take effect the next cycle
`timescale 1ns / 1ps
`include "contactor_closure_checker_top_assert.svh"

module contactor_closure_checker_top #(
    parameter int SAMPLES_PER_ATTEMPT = 3,
    parameter int ADC_BITS            = 12
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [7:0] multiplier, [8] bypass_sense, [20:9] adc_value,
    // [21] conversion_ok, [22] sense_level, [23] zero
    input  logic [ccc_pkg::S_TDATA_W-1:0]     s_tdata,
    // [0] req_type
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] contactor_set, [3:1] outcome, [15:4] settled_sample
    output logic [ccc_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ccc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ccc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import ccc_pkg::*;

    localparam int CNT_W = (SAMPLES_PER_ATTEMPT > 2) ? $clog2(SAMPLES_PER_ATTEMPT) : 1;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_ATTEMPT - 1);
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
        (ADC_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}} : SAMPLE_W'((32'd1 << ADC_BITS) - 32'd1);
    localparam int CMP_W = (ADC_BITS + 11 > 21) ? ADC_BITS + 11 : 21;
    localparam logic [CMP_W-1:0] FS_TIMES5 = CMP_W'(5 * ((1 << ADC_BITS) - 1));
    localparam logic [CMP_W-1:0] SCALE_K   = CMP_W'(CURRENT_SCALE);

    // configuration
    logic [SAMPLE_W-1:0]  max_diff_reg;
    logic [ATTEMPT_W-1:0] max_att_reg;

    // input register
    logic                 in_valid_reg,  in_valid_next;
    logic [22:0]          in_data_reg;
    logic                 in_user_reg;

    // check state
    logic                 checking_reg,  checking_next;
    logic [CNT_W-1:0]     cnt_reg,       cnt_next;
    logic [ATTEMPT_W-1:0] att_reg,       att_next;
    logic [SAMPLE_W-1:0]  win_min_reg,   win_min_next;
    logic [SAMPLE_W-1:0]  win_max_reg,   win_max_next;
    logic [MULT_W-1:0]    mult_reg,      mult_next;
    logic                 bypass_reg,    bypass_next;

    // result register
    logic                 m_valid_reg,   m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg;

    logic                 out_free;
    logic                 process;
    logic                 res_valid;
    outcome_t             res_outcome;
    logic [SAMPLE_W-1:0]  res_sample;

    logic [MULT_W-1:0]    f_mult;
    logic                 f_bypass;
    logic [SAMPLE_W-1:0]  f_adc;
    logic                 f_conv_ok;
    logic                 f_sense;
    logic [SAMPLE_W-1:0]  v;
    logic [SAMPLE_W-1:0]  w_min, w_max;
    logic [CMP_W-1:0]     lhs, rhs;
    logic [ATTEMPT_W-1:0] att_inc;

    assign f_mult    = in_data_reg[7:0];
    assign f_bypass  = in_data_reg[8];
    assign f_adc     = in_data_reg[20:9];
    assign f_conv_ok = in_data_reg[21];
    assign f_sense   = in_data_reg[22];

    assign out_free  = !m_valid_reg || m_tready;
    assign process   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || process;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign v       = f_adc & SAMPLE_MASK;
    assign w_min   = (cnt_reg == '0 || v < win_min_reg) ? v : win_min_reg;
    assign w_max   = (cnt_reg == '0 || v > win_max_reg) ? v : win_max_reg;
    assign lhs     = CMP_W'(v) * SCALE_K;
    assign rhs     = FS_TIMES5 * CMP_W'(mult_reg);
    assign att_inc = att_reg + 8'd1;

    always_comb begin
        checking_next = checking_reg;
        cnt_next      = cnt_reg;
        att_next      = att_reg;
        win_min_next  = win_min_reg;
        win_max_next  = win_max_reg;
        mult_next     = mult_reg;
        bypass_next   = bypass_reg;
        res_valid     = 1'b0;
        res_outcome   = OUT_SET;
        res_sample    = '0;

        if (process) begin
            if (in_user_reg == REQ_START) begin
                checking_next = 1'b1;
                mult_next     = f_mult;
                bypass_next   = f_bypass;
                cnt_next      = '0;
                att_next      = '0;
                win_min_next  = '0;
                win_max_next  = '0;
            end else if (checking_reg) begin
                if (!f_conv_ok) begin
                    res_valid   = 1'b1;
                    res_outcome = OUT_CONV_ERROR;
                end else if (cnt_reg != LAST_CNT) begin
                    cnt_next     = cnt_reg + 1'b1;
                    win_min_next = w_min;
                    win_max_next = w_max;
                end else if (w_max - w_min <= max_diff_reg) begin
                    res_valid  = 1'b1;
                    res_sample = v;
                    if (lhs > rhs) begin
                        res_outcome = OUT_CURR_HIGH;
                    end else if (!bypass_reg && f_sense) begin
                        res_outcome = OUT_PIN_OPEN;
                    end else begin
                        res_outcome = OUT_SET;
                    end
                end else begin
                    cnt_next     = '0;
                    win_min_next = '0;
                    win_max_next = '0;
                    // a zero limit behaves like one; a wrapped count also gives up
                    if (att_inc >= max_att_reg || att_inc == '0) begin
                        res_valid   = 1'b1;
                        res_outcome = OUT_UNSETTLED;
                    end else begin
                        att_next = att_inc;
                    end
                end
                if (res_valid) begin
                    checking_next = 1'b0;
                    cnt_next      = '0;
                    att_next      = '0;
                    win_min_next  = '0;
                    win_max_next  = '0;
                end
            end
        end
    end

    always_comb begin
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (process) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        if (res_valid) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_diff_reg <= SPREAD_LIMIT_RST;
            max_att_reg  <= MAX_ATTEMPTS_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_SPREAD_LIMIT: max_diff_reg <= cfg_wdata;
                REG_MAX_ATTEMPTS: max_att_reg  <= cfg_wdata[ATTEMPT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            checking_reg <= 1'b0;
            cnt_reg      <= '0;
            att_reg      <= '0;
            win_min_reg  <= '0;
            win_max_reg  <= '0;
            mult_reg     <= '0;
            bypass_reg   <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            checking_reg <= checking_next;
            cnt_reg      <= cnt_next;
            att_reg      <= att_next;
            win_min_reg  <= win_min_next;
            win_max_reg  <= win_max_next;
            mult_reg     <= mult_next;
            bypass_reg   <= bypass_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata[22:0];
            in_user_reg <= s_tuser;
        end
        if (res_valid) begin
            m_data_reg <= {res_sample, res_outcome, (res_outcome == OUT_SET)};
        end
    end

    `CCC_ASSERT_NEXT(a_result_ends_check, aclk, aresetn, res_valid, !checking_reg)
    `CCC_ASSERT_NOW(a_idle_window_clear, aclk, aresetn, !checking_reg,
        cnt_reg == '0 && att_reg == '0)
    `CCC_ASSERT_NOW(a_window_ordered, aclk, aresetn, 1'b1, win_min_reg <= win_max_reg)
    `CCC_ASSERT_NOW(a_no_sample_on_fail, aclk, aresetn,
        m_valid_reg && (m_data_reg[3:1] == OUT_CONV_ERROR || m_data_reg[3:1] == OUT_UNSETTLED),
        m_data_reg[15:4] == '0)

endmodule
